[hw/rtl/assert_macros.svh]
// Assertion helpers: clocked on clk, off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be true.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[hw/rtl/kwhm_pkg.sv]
`timescale 1ns / 1ps

package kwhm_pkg;

  localparam int LIST_SLOTS = 16;
  localparam int SLOT_AW    = $clog2(LIST_SLOTS);
  localparam int CNT_W      = $clog2(LIST_SLOTS + 1);

  // Lists taking part in one merge are capped at the smaller of 16 and LIST_SLOTS.
  localparam logic [4:0] MAX_LISTS = (LIST_SLOTS < 16) ? 5'(LIST_SLOTS) : 5'd16;

  localparam logic KIND_ELEM = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef struct packed {
    logic signed [31:0] val;
    logic [3:0]         list;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // True when a orders ahead of b: signed value, then lower list number.
  function automatic logic entry_before(input entry_t a, input entry_t b);
    logic lt;
    begin
      if (a.val != b.val) lt = ($signed(a.val) < $signed(b.val));
      else lt = (a.list < b.list);
      return lt;
    end
  endfunction

endpackage

[hw/rtl/kwhm_ram.sv]
`timescale 1ns / 1ps

module kwhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/k_way_heap_merge_top.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// K-way merge of sorted lists. After reset (or a completed merge) the block
// loads one head per list, list 0 first, and the last load transaction starts
// the first pop. Every later input transaction refills the list named by the
// previous result: a value is pushed, an exhausted mark only pops. A pop scans
// the live entries of the entry RAM one per cycle through a single comparator;
// a transaction that ends the merge (store empty) returns a done result
// (tuser high, data zero). Either one is held back while the previous result
// still waits in the output register. Ties go to the lower list number.
// num_lists (address 0) may be written only while the block is idle; 0 counts
// as 1, above 16 as 16.
module k_way_heap_merge_top (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tuser,   // [0] exhausted
  // stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] merged_value, [35:32] source_list, [39:36] zero
  output logic        m_tuser,   // [0] kind
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SCAN     = 3'd1;
  localparam logic [2:0] ST_SCAN_END = 3'd2;
  localparam logic [2:0] ST_MOVE     = 3'd3;
  localparam logic [2:0] ST_EMIT     = 3'd4;

  logic [2:0]                   state;
  logic [4:0]                   num_lists;
  logic [kwhm_pkg::CNT_W-1:0]   heap_count;
  logic [4:0]                   load_counter;
  logic                         merging;
  logic [3:0]                   pending_list;
  logic [kwhm_pkg::CNT_W-1:0]   scan_idx;
  logic                         rd_valid;
  logic [kwhm_pkg::SLOT_AW-1:0] rd_idx;
  kwhm_pkg::entry_t             best;
  logic [kwhm_pkg::SLOT_AW-1:0] best_idx;
  kwhm_pkg::entry_t             last;
  logic                         res_kind;
  kwhm_pkg::entry_t             res_entry;

  logic                         accept;
  logic                         push;
  logic [kwhm_pkg::CNT_W-1:0]   count_pushed;
  logic [kwhm_pkg::CNT_W-1:0]   last_pos;
  logic [4:0]                   eff_lists;
  logic [4:0]                   lc_inc;
  logic                         cfg_wr;
  logic                         ram_we;
  logic [kwhm_pkg::SLOT_AW-1:0] ram_waddr;
  kwhm_pkg::entry_t             ram_wdata;
  logic [kwhm_pkg::SLOT_AW-1:0] ram_raddr;
  kwhm_pkg::entry_t             ram_rdata;
  logic                         take_cand;
  logic                         emit_fire;

  assign pready = 1'b1;
  assign prdata = {27'd0, num_lists};
  assign cfg_wr = psel & penable & pwrite & pready & ~paddr[2];

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid & s_tready;
  assign emit_fire = (state == ST_EMIT) && (!m_tvalid || m_tready);

  always_comb begin
    eff_lists = num_lists;
    if (eff_lists == 5'd0) eff_lists = 5'd1;
    if (eff_lists > kwhm_pkg::MAX_LISTS) eff_lists = kwhm_pkg::MAX_LISTS;
  end

  assign push         = ~s_tuser && (heap_count < kwhm_pkg::CNT_W'(kwhm_pkg::LIST_SLOTS));
  assign count_pushed = heap_count + kwhm_pkg::CNT_W'(push);
  assign last_pos     = heap_count - kwhm_pkg::CNT_W'(1);
  assign lc_inc       = load_counter + 5'd1;

  // Write port: push on accept, move the last entry into the hole on a pop.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = heap_count[kwhm_pkg::SLOT_AW-1:0];
    ram_wdata.val  = s_tdata;
    ram_wdata.list = merging ? pending_list : load_counter[3:0];
    if (accept) begin
      ram_we = push;
    end else if (state == ST_MOVE) begin
      ram_we    = (kwhm_pkg::CNT_W'(best_idx) != last_pos);
      ram_waddr = best_idx;
      ram_wdata = last;
    end
  end

  assign ram_raddr = scan_idx[kwhm_pkg::SLOT_AW-1:0];

  kwhm_ram #(
    .WIDTH (kwhm_pkg::ENTRY_W),
    .DEPTH (kwhm_pkg::LIST_SLOTS)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign take_cand = rd_valid &&
                     ((rd_idx == '0) || kwhm_pkg::entry_before(ram_rdata, best));

  // Scan datapath: one entry per cycle through the shared comparator.
  always_ff @(posedge clk) begin
    rd_idx <= scan_idx[kwhm_pkg::SLOT_AW-1:0];
    if (take_cand) begin
      best     <= ram_rdata;
      best_idx <= rd_idx;
    end
    if (rd_valid && (kwhm_pkg::CNT_W'(rd_idx) == last_pos)) begin
      last <= ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      num_lists    <= 5'd16;
      heap_count   <= '0;
      load_counter <= 5'd0;
      merging      <= 1'b0;
      pending_list <= 4'd0;
      scan_idx     <= '0;
      rd_valid     <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        num_lists <= pwdata[4:0];
      end
      if (emit_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      rd_valid <= (state == ST_SCAN);

      case (state)
        ST_IDLE: begin
          if (accept) begin
            heap_count <= count_pushed;
            scan_idx   <= '0;
            if (!merging) begin
              if (lc_inc < eff_lists) begin
                load_counter <= lc_inc;
              end else begin
                load_counter <= 5'd0;
                if (count_pushed == '0) begin
                  state <= ST_EMIT;
                end else begin
                  merging <= 1'b1;
                  state   <= ST_SCAN;
                end
              end
            end else if (count_pushed == '0) begin
              merging <= 1'b0;
              state   <= ST_EMIT;
            end else begin
              state <= ST_SCAN;
            end
            res_kind  <= kwhm_pkg::KIND_DONE;
            res_entry <= '0;
          end
        end
        ST_SCAN: begin
          scan_idx <= scan_idx + kwhm_pkg::CNT_W'(1);
          if (scan_idx == last_pos) begin
            state <= ST_SCAN_END;
          end
        end
        ST_SCAN_END: begin
          state <= ST_MOVE;
        end
        ST_MOVE: begin
          heap_count   <= last_pos;
          pending_list <= best.list;
          res_kind     <= kwhm_pkg::KIND_ELEM;
          res_entry    <= best;
          state        <= ST_EMIT;
        end
        ST_EMIT: begin
          // hold until the output register is free
          if (emit_fire) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      m_tuser <= res_kind;
      m_tdata <= {4'd0, res_entry.list, res_entry.val};
    end
  end

  `ASSERT_NEVER(a_count_bound, heap_count > kwhm_pkg::CNT_W'(kwhm_pkg::LIST_SLOTS), "entry count above capacity")
  `ASSERT_CLK(a_best_live, (state == ST_MOVE) |-> (kwhm_pkg::CNT_W'(best_idx) < heap_count), "popped entry outside live range")
  `ASSERT_CLK(a_pop_shrinks, (state == ST_MOVE) |=> (heap_count == $past(heap_count) - kwhm_pkg::CNT_W'(1)), "pop did not remove one entry")

endmodule
